// ===== rtl/physical_frame_list_allocator_core_assert.svh =====
// assertion macros of the frame list allocator port checker
`ifndef PHYSICAL_FRAME_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define PHYSICAL_FRAME_LIST_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFLA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame list allocator port check failed");

// next-cycle implication, sampled on clk, off during reset
`define PFLA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame list allocator port check failed");

`endif

// ===== rtl/pfla_pkg.sv =====
// types, codes and defaults of the physical frame list allocator
package pfla_pkg;

	localparam int FRAME_COUNT_DEF = 4096;
	localparam int LIST_COUNT_DEF  = 3;

	// command codes
	localparam logic [1:0] CMD_POPULATE = 2'd0;
	localparam logic [1:0] CMD_ALLOC    = 2'd1;
	localparam logic [1:0] CMD_FREE     = 2'd2;
	localparam logic [1:0] CMD_NOP      = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_FRAMES = 2'd1;
	localparam logic [1:0] STATUS_NULL      = 2'd2;

	// list numbers
	localparam int LIST_FREE     = 0;
	localparam int LIST_NONPAGED = 1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] frame_index;
		logic [12:0] page_count;
		logic        to_in_use;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] allocated_frame;
		logic [11:0] free_count;
		logic [11:0] in_use_count;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic pick;
		logic walk;
		logic seal;
		logic read;
		logic link;
		logic push;
		logic back;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       run_empty;
		logic       walk_last;
		logic       alloc_empty;
		logic       free_bad;
	} dp_stat_t;

endpackage

// ===== rtl/pfla_ctrl.sv =====
// sequencer of the frame list allocator
module pfla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pfla_pkg::dp_stat_t stat,
	output pfla_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import pfla_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DISPATCH = 9'b000000010,
		ST_WALK     = 9'b000000100,
		ST_SEAL     = 9'b000001000,
		ST_READ     = 9'b000010000,
		ST_LINK     = 9'b000100000,
		ST_PUSH     = 9'b001000000,
		ST_BACK     = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.pick = 1'b1;
				case (stat.op)
					CMD_POPULATE: state_d = stat.run_empty ? ST_DONE : ST_WALK;
					CMD_ALLOC:    state_d = stat.alloc_empty ? ST_DONE : ST_READ;
					CMD_FREE:     state_d = stat.free_bad ? ST_DONE : ST_READ;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_SEAL;
				end
			end
			ST_SEAL: begin
				cmd.seal = 1'b1;
				state_d  = ST_DONE;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_LINK;
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				state_d  = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_BACK;
			end
			ST_BACK: begin
				cmd.back = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/pfla_dp.sv =====
// link tables, list registers and result registers of the frame list allocator
module pfla_dp #(
	parameter int FRAME_COUNT = pfla_pkg::FRAME_COUNT_DEF,
	parameter int LIST_COUNT  = pfla_pkg::LIST_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfla_pkg::req_t     req,
	input  pfla_pkg::dp_cmd_t  cmd,
	output pfla_pkg::dp_stat_t stat,
	output pfla_pkg::rsp_t     rsp
);
	import pfla_pkg::*;

	localparam int AW = $clog2(FRAME_COUNT);
	localparam int LW = $clog2(LIST_COUNT);
	localparam int CW = ((AW > 13) ? AW : 13) + 1;
	localparam logic [CW-1:0] FC_C = CW'(FRAME_COUNT);
	localparam logic [2:0]    LC_C = 3'(LIST_COUNT);
	localparam logic [LW-1:0] L_FREE = LW'(LIST_FREE);
	localparam logic [LW-1:0] L_NONP = LW'(LIST_NONPAGED);

	// link tables
	logic [AW-1:0] next_mem [FRAME_COUNT];
	logic [AW-1:0] prev_mem [FRAME_COUNT];
	logic [1:0]    tag_mem  [FRAME_COUNT];

	// list registers
	logic [AW-1:0] head_q [LIST_COUNT];
	logic [AW-1:0] tail_q [LIST_COUNT];
	logic [11:0]   len_q  [LIST_COUNT];

	// captured transaction and work registers
	logic [1:0]    op_q;
	logic          tin_q;
	logic [11:0]   fi_q;
	logic [CW-1:0] f_q;
	logic [12:0]   cnt_q;
	logic [AW-1:0] x_q;
	logic [AW-1:0] hv_q;
	logic [AW-1:0] last_q;
	logic          self_q;
	logic [AW-1:0] next_rd_q;
	logic [AW-1:0] prev_rd_q;
	logic [1:0]    tag_rd_q;
	logic [1:0]    status_q;
	logic [11:0]   alloc_q;

	function automatic logic link_ok(input logic [AW-1:0] l);
		return (l != '0) && (CW'(l) < FC_C);
	endfunction

	logic [LW-1:0] v;
	logic [LW-1:0] u;
	logic          unl_en;
	logic [AW-1:0] f_a;
	logic [AW-1:0] h_v;
	logic          fi_ok;

	// list selection for the current transaction
	always_comb begin
		case (op_q)
			CMD_POPULATE: v = tin_q ? L_NONP : L_FREE;
			CMD_ALLOC:    v = L_NONP;
			default:      v = L_FREE;
		endcase
		u      = (op_q == CMD_ALLOC) ? L_FREE : LW'(tag_rd_q);
		unl_en = (op_q == CMD_ALLOC) || ({1'b0, tag_rd_q} < LC_C);
	end

	assign f_a   = AW'(f_q);
	assign h_v   = head_q[v];
	assign fi_ok = (fi_q != '0) && (CW'(fi_q) < FC_C);

	assign stat.op          = op_q;
	assign stat.run_empty   = (cnt_q == '0) || (f_q >= FC_C);
	assign stat.walk_last   = (cnt_q == 13'd1) || ((f_q + CW'(1)) >= FC_C);
	assign stat.alloc_empty = (len_q[L_FREE] == '0) || !link_ok(head_q[L_FREE]);
	assign stat.free_bad    = !fi_ok;

	assign rsp.status          = status_q;
	assign rsp.allocated_frame = alloc_q;
	assign rsp.free_count      = len_q[L_FREE];
	assign rsp.in_use_count    = len_q[L_NONP];

	// write port selection of each table
	logic          nx_we, pv_we, tg_we;
	logic [AW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, tg_wa;
	logic [1:0]    tg_wd;

	always_comb begin
		nx_we = 1'b0;
		nx_wa = f_a;
		nx_wd = h_v;
		pv_we = 1'b0;
		pv_wa = h_v;
		pv_wd = f_a;
		tg_we = 1'b0;
		tg_wa = f_a;
		tg_wd = 2'(v);
		if (cmd.walk) begin
			nx_we = 1'b1;
			pv_we = link_ok(h_v);
			tg_we = 1'b1;
		end
		if (cmd.seal) begin
			pv_we = !self_q;
			pv_wa = last_q;
			pv_wd = '0;
		end
		if (cmd.link) begin
			nx_we = unl_en && link_ok(prev_rd_q);
			nx_wa = prev_rd_q;
			nx_wd = next_rd_q;
			pv_we = unl_en && link_ok(next_rd_q);
			pv_wa = next_rd_q;
			pv_wd = prev_rd_q;
		end
		if (cmd.push) begin
			nx_we = 1'b1;
			nx_wa = x_q;
			nx_wd = h_v;
			pv_we = 1'b1;
			pv_wa = x_q;
			pv_wd = '0;
			tg_we = 1'b1;
			tg_wa = x_q;
		end
		if (cmd.back) begin
			pv_we = link_ok(hv_q);
			pv_wa = hv_q;
			pv_wd = x_q;
		end
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (tg_we) begin
			tag_mem[tg_wa] <= tg_wd;
		end
		if (cmd.read) begin
			next_rd_q <= next_mem[x_q];
			prev_rd_q <= prev_mem[x_q];
			tag_rd_q  <= tag_mem[x_q];
		end
	end

	// transaction capture and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.cmd;
			tin_q <= req.to_in_use;
			fi_q  <= req.frame_index;
			if (req.frame_index == '0) begin
				f_q   <= CW'(1);
				cnt_q <= (req.page_count != '0) ? req.page_count - 13'd1 : '0;
			end else begin
				f_q   <= CW'(req.frame_index);
				cnt_q <= req.page_count;
			end
		end
		if (cmd.pick) begin
			x_q      <= (op_q == CMD_ALLOC) ? head_q[L_FREE] : AW'(fi_q);
			status_q <= STATUS_OK;
			alloc_q  <= '0;
			if (op_q == CMD_ALLOC) begin
				if (stat.alloc_empty) begin
					status_q <= STATUS_NO_FRAMES;
				end else begin
					alloc_q <= 12'(head_q[L_FREE]);
				end
			end else if (op_q == CMD_FREE && !fi_ok) begin
				status_q <= STATUS_NULL;
			end
		end
		if (cmd.walk) begin
			f_q    <= f_q + CW'(1);
			cnt_q  <= cnt_q - 13'd1;
			last_q <= f_a;
			self_q <= (h_v == f_a);
		end
		if (cmd.push) begin
			hv_q <= h_v;
		end
	end

	// list heads, tails and lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			if (cmd.walk || cmd.push) begin
				head_q[v] <= cmd.walk ? f_a : x_q;
				if (tail_q[v] == '0) begin
					tail_q[v] <= cmd.walk ? f_a : x_q;
				end
				len_q[v] <= len_q[v] + 12'd1;
			end
			if (cmd.link && unl_en) begin
				if (x_q == head_q[u]) begin
					head_q[u] <= next_rd_q;
				end
				if (x_q == tail_q[u]) begin
					tail_q[u] <= prev_rd_q;
				end
				len_q[u] <= len_q[u] - 12'd1;
			end
		end
	end

endmodule

// ===== rtl/physical_frame_list_allocator_core.sv =====
// top level of the physical frame list allocator
// Usage: drive req and raise start; the transaction is taken at a rising edge
// with start high and busy low. busy stays high until the result is shown.
// The result appears on rsp for exactly one cycle with done high; the receiver
// must take it then, there is no back-pressure.
// Steps after the accepting edge:
//   populate of n inserted frames: dispatch, n walk steps, seal, result (dispatch
//   and result when nothing is inserted); the walk writes one frame per cycle
//   through the single write port of each link table;
//   allocate and free: dispatch, link read, unlink, push, back link, result,
//   steps set by the registered read and single write port of the tables;
//   rejected allocate, rejected free and the no-op command: dispatch, result.
// A new transaction is taken in the cycle after done.
// Reset empties all three lists; the link tables keep undefined contents,
// which a free also reads for a frame never placed on a list.
module physical_frame_list_allocator_core #(
	parameter int FRAME_COUNT = pfla_pkg::FRAME_COUNT_DEF,
	parameter int LIST_COUNT  = pfla_pkg::LIST_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pfla_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output pfla_pkg::rsp_t rsp
);
	import pfla_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pfla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pfla_dp #(
		.FRAME_COUNT (FRAME_COUNT),
		.LIST_COUNT  (LIST_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/pfla_checker.sv =====
// port checker of the frame list allocator and its bind
`include "physical_frame_list_allocator_core_assert.svh"

module pfla_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input pfla_pkg::rsp_t rsp
);
	import pfla_pkg::*;

	// an accepted transaction makes the block busy
	`PFLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// the result strobe lasts one cycle
	`PFLA_ASSERT_NEXT(a_done_single, done, !done)
	// a result only comes while a transaction is open
	`PFLA_ASSERT_NOW(a_done_busy, done, busy)
	// a failed transaction returns no frame
	`PFLA_ASSERT_NOW(a_fail_no_frame, done && (rsp.status != STATUS_OK), rsp.allocated_frame == '0)

endmodule

bind physical_frame_list_allocator_core pfla_checker u_pfla_checker (.*);

// ===== tb/physical_frame_list_allocator_core_checker.sv =====
// checker for the frame list allocator: mirrors the three lists and compares every result
module physical_frame_list_allocator_core_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  logic           done,
	input  pfla_pkg::req_t req,
	input  pfla_pkg::rsp_t rsp,
	output int             errors,
	output int             pending,
	output int             checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import pfla_pkg::*;

	localparam int FRAMES = FRAME_COUNT_DEF;
	localparam int LISTS  = LIST_COUNT_DEF;

	// mirrored link tables and list descriptors
	logic [11:0] nxt_tbl [FRAMES];
	logic [11:0] prv_tbl [FRAMES];
	logic [1:0]  own_tbl [FRAMES];
	logic [11:0] head_of [LISTS];
	logic [11:0] tail_of [LISTS];
	logic [11:0] len_of  [LISTS];

	rsp_t rsp_queue [$];

	initial begin
		errors = 0;
		checked = 0;
		for (int i = 0; i < FRAMES; i++) begin
			nxt_tbl[i] = '0;
			prv_tbl[i] = '0;
			own_tbl[i] = '0;
		end
	end

	assign pending = rsp_queue.size();

	task automatic report(input string msg);
		$display("checker mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// push frame f onto the head of list l
	function automatic void push_frame(input int l, input logic [11:0] f);
		logic [11:0] h;
		h = head_of[l];
		nxt_tbl[f] = h;
		prv_tbl[f] = '0;
		own_tbl[f] = l[1:0];
		if (h != 0)
			prv_tbl[h] = f;
		head_of[l] = f;
		if (tail_of[l] == 0)
			tail_of[l] = f;
		len_of[l] = len_of[l] + 12'd1;
	endfunction

	// take frame f out of list l
	function automatic void unlink_frame(input int l, input logic [11:0] f);
		logic [11:0] n, p;
		n = nxt_tbl[f];
		p = prv_tbl[f];
		if (f == head_of[l])
			head_of[l] = n;
		if (f == tail_of[l])
			tail_of[l] = p;
		if (p != 0)
			nxt_tbl[p] = n;
		if (n != 0)
			prv_tbl[n] = p;
		len_of[l] = len_of[l] - 12'd1;
	endfunction

	// apply one transaction to the mirror and return the result it should give
	function automatic rsp_t list_step(input req_t r);
		rsp_t o;
		int f, cnt, tgt;
		logic [11:0] h;
		o = '0;
		o.status = STATUS_OK;
		tgt = r.to_in_use ? LIST_NONPAGED : LIST_FREE;
		case (r.cmd)
			CMD_POPULATE: begin
				f = r.frame_index;
				cnt = r.page_count;
				if (f == 0) begin
					f = 1;
					if (cnt > 0)
						cnt--;
				end
				for (int k = 0; k < cnt; k++) begin
					if (f >= FRAMES)
						break;
					push_frame(tgt, f[11:0]);
					f++;
				end
			end
			CMD_ALLOC: begin
				h = head_of[LIST_FREE];
				if (len_of[LIST_FREE] == 0 || h == 0) begin
					o.status = STATUS_NO_FRAMES;
				end else begin
					unlink_frame(LIST_FREE, h);
					push_frame(LIST_NONPAGED, h);
					o.allocated_frame = h;
				end
			end
			CMD_FREE: begin
				if (r.frame_index == 0) begin
					o.status = STATUS_NULL;
				end else begin
					if (own_tbl[r.frame_index] < LISTS)
						unlink_frame(own_tbl[r.frame_index], r.frame_index);
					push_frame(LIST_FREE, r.frame_index);
				end
			end
			default: ;
		endcase
		o.free_count = len_of[LIST_FREE];
		o.in_use_count = len_of[LIST_NONPAGED];
		return o;
	endfunction

	// result compare, then capture of accepted transactions
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int l = 0; l < LISTS; l++) begin
				head_of[l] = '0;
				tail_of[l] = '0;
				len_of[l] = '0;
			end
		end else begin
			if (done) begin
				if (rsp_queue.size() == 0) begin
					report("result with no transaction waiting");
				end else begin
					e = rsp_queue.pop_front();
					checked++;
					if (rsp.status !== e.status)
						report($sformatf("status %0d, want %0d", rsp.status, e.status));
					if (rsp.allocated_frame !== e.allocated_frame)
						report($sformatf("allocated_frame %0d, want %0d",
							rsp.allocated_frame, e.allocated_frame));
					if (rsp.free_count !== e.free_count)
						report($sformatf("free_count %0d, want %0d",
							rsp.free_count, e.free_count));
					if (rsp.in_use_count !== e.in_use_count)
						report($sformatf("in_use_count %0d, want %0d",
							rsp.in_use_count, e.in_use_count));
				end
			end
			if (start && !busy)
				rsp_queue.push_back(list_step(req));
		end
	end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the physical frame list allocator
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pfla_pkg::*;

	logic clk, arst_n, start, busy, done;
	req_t req;
	rsp_t rsp;
	int errors, pending, checked;

	// frames that have been placed on a list at least once
	bit populated [4096];
	logic [11:0] pop_frames [$];
	int n_pop, n_alloc, n_free, n_nop;
	bit idle_ok;

	physical_frame_list_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	physical_frame_list_allocator_core_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.req(req), .rsp(rsp), .errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("testbench: done, errors");
		$finish;
	end

	// hand one transaction over; returns at the falling edge after acceptance, or after a random idle gap with start low
	task automatic send(input req_t r);
		bit taken;
		start <= 1'b1;
		req <= r;
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
		if (idle_ok && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic populate(input int fi, input int cnt, input bit tgt);
		req_t r;
		int f, c;
		r = '0;
		r.cmd = CMD_POPULATE;
		r.frame_index = fi[11:0];
		r.page_count = cnt[12:0];
		r.to_in_use = tgt;
		f = fi;
		c = cnt;
		if (f == 0) begin
			f = 1;
			if (c > 0)
				c--;
		end
		for (int k = 0; k < c && f < 4096; k++, f++)
			if (!populated[f]) begin
				populated[f] = 1'b1;
				pop_frames.push_back(f[11:0]);
			end
		n_pop++;
		send(r);
	endtask

	task automatic simple_cmd(input logic [1:0] c, input logic [11:0] fi);
		req_t r;
		r = '0;
		r.cmd = c;
		r.frame_index = fi;
		r.page_count = 13'($urandom);
		r.to_in_use = 1'($urandom);
		if (c == CMD_ALLOC)
			n_alloc++;
		else if (c == CMD_FREE)
			n_free++;
		else
			n_nop++;
		send(r);
	endtask

	// free a frame known to be on a list, or the null frame if none is
	task automatic free_some;
		if (pop_frames.size() == 0)
			simple_cmd(CMD_FREE, 12'd0);
		else
			simple_cmd(CMD_FREE, pop_frames[$urandom_range(0, pop_frames.size() - 1)]);
	endtask

	initial begin
		int w, sel;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_ok = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty lists, null frame, zero-length runs, run from frame 0
		simple_cmd(CMD_ALLOC, 12'd0);
		simple_cmd(CMD_FREE, 12'd0);
		simple_cmd(CMD_NOP, 12'hfff);
		populate(0, 0, 1'b0);
		populate(0, 1, 1'b0);
		populate(0, 4, 1'b0);
		simple_cmd(CMD_ALLOC, 12'd0);
		simple_cmd(CMD_ALLOC, 12'd0);
		simple_cmd(CMD_ALLOC, 12'd0);
		simple_cmd(CMD_ALLOC, 12'd0);
		populate(4090, 20, 1'b1);
		populate(4095, 1, 1'b0);
		simple_cmd(CMD_FREE, 12'hfff);
		simple_cmd(CMD_FREE, 12'd2);
		simple_cmd(CMD_FREE, 12'd4093);
		// re-insert of frames already on a list
		populate(1, 3, 1'b1);
		simple_cmd(CMD_ALLOC, 12'd0);
		// full-range run, makes the counters wrap
		populate(0, 4096, 1'b0);
		populate(2048, 4096, 1'b1);
		simple_cmd(CMD_ALLOC, 12'd0);
		simple_cmd(CMD_FREE, 12'd1);
		simple_cmd(CMD_NOP, 12'd0);

		// random mix, mostly small runs, allocates and frees of populated frames
		for (int i = 0; i < 1500; i++) begin
			if (i >= 1300)
				idle_ok = 1'b0;
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				w = $urandom_range(0, 19);
				populate($urandom_range(0, 4095),
					(w == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8),
					1'($urandom));
			end else if (sel < 55) begin
				simple_cmd(CMD_ALLOC, 12'($urandom));
			end else if (sel < 90) begin
				free_some();
			end else if (sel < 95) begin
				simple_cmd(CMD_FREE, 12'd0);
			end else begin
				simple_cmd(CMD_NOP, 12'($urandom));
			end
		end
		start <= 1'b0;

		// drain, then a short settle
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d populate, %0d allocate, %0d free, %0d no-op transactions",
			n_pop, n_alloc, n_free, n_nop);
		$display("%0d results compared, %0d frames ever populated",
			checked, pop_frames.size());
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
